// ===== design/siy_operand_parse_and_encode_defines.svh =====
// ----------------------------------------------------------------------------
// SIY operand parser: assertion macros
// Shared assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef SIY_OPERAND_PARSE_AND_ENCODE_DEFINES_SVH
`define SIY_OPERAND_PARSE_AND_ENCODE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define SIY_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("siy assertion failed");

// checked at every edge, reset included
`define SIY_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("siy assertion failed");

`else

`define SIY_ASSERT(lbl, prop)
`define SIY_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== design/siy_pkg.sv =====
// ----------------------------------------------------------------------------
// SIY operand parser package
// Beat types, parse phases, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package siy_pkg;

	typedef struct packed {
		logic [7:0]  char_code;
		logic [15:0] opcode;
		logic        imm_unused;
	} char_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] instruction;
	} res_t;

	typedef enum logic [1:0] {
		PH_D1,
		PH_B1,
		PH_I2,
		PH_DONE
	} phase_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NONHEX   = 3'd1;
	localparam logic [2:0] ST_LENGTH   = 3'd2;
	localparam logic [2:0] ST_MISSING  = 3'd3;
	localparam logic [2:0] ST_TOO_MANY = 3'd4;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;

	localparam logic [2:0] D1_DIGITS = 3'd5;
	localparam logic [2:0] B1_DIGITS = 3'd1;
	localparam logic [2:0] I2_DIGITS = 3'd2;

	// {digit ok, digit value}
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

endpackage

// ===== design/siy_parse.sv =====
// ----------------------------------------------------------------------------
// SIY operand parse state
// Per-token field state; one character step per cycle while step is high, result on NUL.
// ----------------------------------------------------------------------------
`include "siy_operand_parse_and_encode_defines.svh"

module siy_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  siy_pkg::char_t item,
	output logic          is_end,
	output siy_pkg::res_t result
);
	import siy_pkg::*;

	phase_t      phase_q, n_phase;
	logic [2:0]  cnt_q, n_cnt;
	logic [19:0] acc_q, n_acc;
	logic        bad_q, n_bad;
	logic [19:0] disp_q, n_disp;
	logic [3:0]  base_q, n_base;
	logic [7:0]  imm_q, n_imm;
	logic        stop_q, n_stop;
	logic [2:0]  stat_q, n_stat;

	logic [4:0]  hx;
	logic [2:0]  limit;
	phase_t      f_phase;
	logic        f_stop;
	logic [2:0]  f_stat;
	logic [3:0]  f_base;
	logic [7:0]  f_imm;
	logic [2:0]  f_status;

	assign is_end = (item.char_code == CHAR_NUL);

	always_comb begin
		n_phase  = phase_q;
		n_cnt    = cnt_q;
		n_acc    = acc_q;
		n_bad    = bad_q;
		n_disp   = disp_q;
		n_base   = base_q;
		n_imm    = imm_q;
		n_stop   = stop_q;
		n_stat   = stat_q;
		f_phase  = phase_q;
		f_stop   = stop_q;
		f_stat   = stat_q;
		f_base   = base_q;
		f_imm    = imm_q;
		f_status = ST_OK;
		result   = '0;
		hx       = hex_of(item.char_code);

		unique case (phase_q)
			PH_D1:   limit = D1_DIGITS;
			PH_B1:   limit = B1_DIGITS;
			default: limit = I2_DIGITS;
		endcase

		if (!is_end) begin
			if (!stop_q) begin
				if (phase_q == PH_DONE) begin
					n_stop = 1'b1;
					n_stat = ST_TOO_MANY;
				end else if (item.char_code == CHAR_COMMA) begin
					if (cnt_q == 3'd0) begin
						n_stop = 1'b1;
						n_stat = ST_MISSING;
					end else if (bad_q) begin
						n_stop = 1'b1;
						n_stat = ST_NONHEX;
					end else begin
						unique case (phase_q)
							PH_D1: begin
								n_disp  = acc_q;
								n_phase = PH_B1;
							end
							PH_B1: begin
								n_base  = acc_q[3:0];
								n_phase = item.imm_unused ? PH_DONE : PH_I2;
							end
							default: begin
								n_imm   = acc_q[7:0];
								n_phase = PH_DONE;
							end
						endcase
						n_cnt = 3'd0;
						n_acc = 20'd0;
						n_bad = 1'b0;
						if (n_phase == PH_DONE) begin
							n_stop = 1'b1;
							n_stat = ST_TOO_MANY;
						end
					end
				end else if (cnt_q >= limit) begin
					n_stop = 1'b1;
					n_stat = ST_LENGTH;
				end else begin
					n_bad = bad_q | ~hx[4];
					n_acc = {acc_q[15:0], hx[4] ? hx[3:0] : 4'd0};
					n_cnt = cnt_q + 3'd1;
				end
			end
		end else begin
			// end of token: close the open field, then build the result
			if (!stop_q) begin
				if (phase_q == PH_D1) begin
					f_stop = 1'b1;
					f_stat = (cnt_q >= D1_DIGITS) ? ST_LENGTH : ST_MISSING;
				end else if (phase_q == PH_DONE) begin
					f_stop = 1'b1;
					f_stat = ST_TOO_MANY;
				end else if (cnt_q == 3'd0) begin
					f_stop = 1'b1;
					f_stat = ST_MISSING;
				end else if (bad_q) begin
					f_stop = 1'b1;
					f_stat = ST_NONHEX;
				end else begin
					if (phase_q == PH_B1) begin
						f_base  = acc_q[3:0];
						f_phase = item.imm_unused ? PH_DONE : PH_I2;
					end else begin
						f_imm   = acc_q[7:0];
						f_phase = PH_DONE;
					end
					if (f_phase != PH_DONE) begin
						f_stop = 1'b1;
						f_stat = ST_MISSING;
					end
				end
			end
			f_status = f_stop ? f_stat : ST_OK;
			result.status = f_status;
			if (f_status == ST_OK) begin
				result.instruction = {item.opcode[15:8], f_imm, f_base, disp_q[11:8],
					disp_q[7:0], disp_q[19:12], item.opcode[7:0]};
			end
			n_phase = PH_D1;
			n_cnt   = 3'd0;
			n_acc   = 20'd0;
			n_bad   = 1'b0;
			n_disp  = 20'd0;
			n_base  = 4'd0;
			n_imm   = 8'd0;
			n_stop  = 1'b0;
			n_stat  = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_D1;
			cnt_q   <= 3'd0;
			acc_q   <= 20'd0;
			bad_q   <= 1'b0;
			disp_q  <= 20'd0;
			base_q  <= 4'd0;
			imm_q   <= 8'd0;
			stop_q  <= 1'b0;
			stat_q  <= ST_OK;
		end else if (step) begin
			phase_q <= n_phase;
			cnt_q   <= n_cnt;
			acc_q   <= n_acc;
			bad_q   <= n_bad;
			disp_q  <= n_disp;
			base_q  <= n_base;
			imm_q   <= n_imm;
			stop_q  <= n_stop;
			stat_q  <= n_stat;
		end
	end

	`SIY_ASSERT_ALWAYS(a_status_only_when_stopped, !stop_q |-> stat_q == ST_OK)
	`SIY_ASSERT(a_done_implies_stopped, phase_q == PH_DONE |-> stop_q)
	`SIY_ASSERT(a_count_in_range, cnt_q <= D1_DIGITS)
	`SIY_ASSERT(a_end_clears, step && is_end |=> !stop_q && phase_q == PH_D1 && cnt_q == 3'd0)

endmodule

// ===== design/siy_operand_parse_and_encode.sv =====
// ----------------------------------------------------------------------------
// SIY operand parser and encoder
// Parses D1,B1[,I2] hex operand text and emits the packed SIY instruction.
// ----------------------------------------------------------------------------
// Usage:
//   char channel: one operand character per beat (char_valid/char_ready),
//   with the opcode and imm_unused flag held steady through the token. A
//   NUL character ends the token.
//   res channel: one beat per token (res_valid/res_ready) carrying the status
//   and the 48-bit instruction word; instruction is zero unless status is ok.
//   Throughput: one character per cycle, unless the stall below holds. Each
//   character passes an input register and then the field-parse logic; a NUL
//   beat loads the result register, which raises res_valid.
//   The output register decouples the sides: characters keep flowing while a
//   result waits. Only a second NUL stalls: it is held in the input register,
//   with char_ready low, until the pending result is taken.
//   Reset clears both valid flags and all parse state; the next character
//   starts a fresh token.
// ----------------------------------------------------------------------------
`include "siy_operand_parse_and_encode_defines.svh"

module siy_operand_parse_and_encode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           char_valid,
	output logic           char_ready,
	input  siy_pkg::char_t char_beat,
	output logic           res_valid,
	input  logic           res_ready,
	output siy_pkg::res_t  res_beat
);
	import siy_pkg::*;

	logic  valid_s1;
	char_t item_s1;
	logic  adv;
	logic  is_end;
	res_t  result;
	logic  res_valid_q;
	res_t  res_q;

	assign adv        = valid_s1 && (!is_end || !res_valid_q || res_ready);
	assign char_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid) begin
			item_s1 <= char_beat;
		end
	end

	siy_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.is_end (is_end),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && is_end) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_end) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res_beat  = res_q;

	`SIY_ASSERT(a_result_from_end, $rose(res_valid_q) |-> $past(adv && is_end))
	`SIY_ASSERT(a_stall_cause, !char_ready |-> valid_s1 && is_end && res_valid_q && !res_ready)
	`SIY_ASSERT(a_error_word_zero, res_valid_q && res_q.status != ST_OK |-> res_q.instruction == 48'd0)

endmodule
